@@ hw/rtl/lgbfl_pkg.sv @@
`timescale 1ns / 1ps
package lgbfl_pkg;

    localparam int TABLE_DEPTH      = 1024;
    localparam int TABLE_AW         = 10;
    localparam int DIST_POINTS_DEF  = 64;
    localparam int SIGMA_POINTS_DEF = 16;
    // Grid coordinates are carried at the width of the largest allowed grid.
    localparam int GRID_IW          = 9;

    localparam logic signed [19:0] LOG10_2_Q20     = 20'sd315653;
    localparam logic signed [27:0] REF_DB_Q16      = 28'sd3246812;
    localparam logic signed [23:0] DIST_FLOOR_LOG  = -24'sd65536;
    localparam logic signed [23:0] SIGMA_FLOOR_LOG = -24'sd216335;
    localparam logic signed [19:0] NO_SIGNAL_DB    = -20'sd51200;
    localparam logic signed [19:0] FS_MAX          = 20'sd524287;
    localparam logic signed [19:0] FS_MIN          = -20'sd524288;

    localparam logic signed [18:0] LOG_DIST_MIN_RST  = -19'sd65536;
    localparam logic [23:0]        DIST_STEPS_RST    = 24'd655360;
    localparam logic signed [18:0] LOG_SIGMA_MIN_RST = -19'sd216335;
    localparam logic [23:0]        SIGMA_STEPS_RST   = 24'd262144;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_QUERY = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        CFG_LOG_DIST_MIN  = 2'd0,
        CFG_DIST_STEPS    = 2'd1,
        CFG_LOG_SIGMA_MIN = 2'd2,
        CFG_SIGMA_STEPS   = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [4:0]  e;
        logic [3:0]  k;
        logic [26:0] r;
    } t_lnorm;

    typedef struct packed {
        logic [GRID_IW-1:0] idx;
        logic [16:0]        t;
    } t_gpos;

    // log2(1 + k/16) in Q16.
    function automatic logic [16:0] log2_seg(input logic [4:0] k);
        case (k)
            5'd0:    return 17'd0;
            5'd1:    return 17'd5732;
            5'd2:    return 17'd11136;
            5'd3:    return 17'd16248;
            5'd4:    return 17'd21098;
            5'd5:    return 17'd25711;
            5'd6:    return 17'd30109;
            5'd7:    return 17'd34312;
            5'd8:    return 17'd38336;
            5'd9:    return 17'd42196;
            5'd10:   return 17'd45904;
            5'd11:   return 17'd49472;
            5'd12:   return 17'd52911;
            5'd13:   return 17'd56229;
            5'd14:   return 17'd59434;
            5'd15:   return 17'd62534;
            default: return 17'd65536;
        endcase
    endfunction

    // Leading-one position and normalized fraction split into segment and remainder.
    function automatic t_lnorm log2_norm(input logic [31:0] x);
        t_lnorm      o;
        logic [31:0] n;
        logic [4:0]  e;
        e = '0;
        for (int i = 0; i < 32; i++) begin
            if (x[i]) e = 5'(i);
        end
        n   = x << (5'd31 - e);
        o.e = e;
        o.k = n[30:27];
        o.r = n[26:0];
        return o;
    endfunction

    // Q16 log2 with the input's fraction bits removed.
    function automatic logic signed [23:0] log2_q16(input t_lnorm a, input logic [4:0] frac);
        logic [16:0] s0;
        logic [16:0] s1;
        logic [39:0] m;
        s0 = log2_seg({1'b0, a.k});
        s1 = log2_seg({1'b0, a.k} + 5'd1);
        m  = 40'(s1 - s0) * 40'(a.r);
        return $signed({3'b0, a.e, 16'b0}) + $signed({7'b0, s0})
             + $signed({11'b0, m[39:27]}) - $signed({3'b0, frac, 16'b0});
    endfunction

    function automatic logic signed [23:0] log10_round(input logic signed [43:0] p);
        logic signed [43:0] t;
        t = p + 44'sd524288;
        return 24'(t >>> 20);
    endfunction

    // Clamp a Q32 grid position to [0, last] and split it into row and Q16 weight.
    function automatic t_gpos grid_pos(input logic signed [49:0] pos,
                                       input logic [GRID_IW-1:0] last);
        t_gpos              g;
        logic signed [49:0] top;
        top = $signed({9'b0, last, 32'b0});
        if (pos <= 50'sd0) begin
            g.idx = '0;
            g.t   = '0;
        end else if (pos >= top) begin
            g.idx = last - 1'b1;
            g.t   = 17'd65536;
        end else begin
            g.idx = pos[32 +: GRID_IW];
            g.t   = {1'b0, pos[31:16]};
        end
        return g;
    endfunction

endpackage

@@ hw/rtl/log_grid_bilinear_field_lookup.sv @@
`timescale 1ns / 1ps
// Field-strength estimator over a log-spaced attenuation grid.
// Input channel (i_in_valid / o_in_ready): one word per accepted beat. A load word
// (operation 0) writes entry_index with entry_value and produces no result. A query
// word (operation 1) produces exactly one result word on the output channel.
// Output channel (o_out_valid / i_out_ready): field_strength in Q12.8 dBuV/m and
// the no_signal flag, which is set with -200 dB when distance or power is zero.
// Configuration channel (i_cfg_valid / o_cfg_ready) is always ready and writes the
// grid origin and steps-per-decade registers; write it only while the block is idle.
// Throughput: one word per cycle while the output is not stalled. The pipeline has nine
// stages plus the output register; the table is held twice so that the four corner
// reads of a query are served by two memories with two read ports each, all in the same cycle.
// A stalled receiver fills empty stages first; the input drops ready only when
// every stage holds a word and the output word is not taken.
// Reset clears the pipeline and restores the register defaults. Table contents are
// not cleared; an entry must be loaded before a query reads it.
module log_grid_bilinear_field_lookup #(
    parameter int DIST_POINTS  = lgbfl_pkg::DIST_POINTS_DEF,
    parameter int SIGMA_POINTS = lgbfl_pkg::SIGMA_POINTS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_operation,
    input  logic [9:0]         i_entry_index,
    input  logic signed [19:0] i_entry_value,
    input  logic [23:0]        i_distance,
    input  logic [23:0]        i_conductivity,
    input  logic [31:0]        i_power,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [19:0] o_field_strength,
    output logic               o_no_signal,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [23:0]        i_cfg_data
);

    localparam int AW = lgbfl_pkg::TABLE_AW;
    localparam int IW = lgbfl_pkg::GRID_IW;
    localparam logic [IW-1:0] DLAST = IW'(DIST_POINTS - 1);
    localparam logic [IW-1:0] SLAST = IW'(SIGMA_POINTS - 1);

    // Configuration registers.
    logic signed [18:0] r_log_dist_min;
    logic [23:0]        r_dist_steps;
    logic signed [18:0] r_log_sigma_min;
    logic [23:0]        r_sigma_steps;

    // Pipeline control.
    logic [9:1]  r_v;
    logic [10:1] go;
    logic        r_o_valid;

    logic [9:1]  r_op;
    logic [9:1]  r_ns;
    logic [3:1]  r_cz;
    logic [AW-1:0]      r_idx [6:1];
    logic signed [19:0] r_val [6:1];

    // Query payload per stage.
    lgbfl_pkg::t_lnorm  r_s1_nd, r_s1_np, r_s1_nc;
    logic signed [23:0] r_s2_ld, r_s2_lp, r_s2_lc;
    logic signed [43:0] r_s3_pd, r_s3_pp, r_s3_pc;
    logic signed [27:0] r_s4_ref;
    logic signed [24:0] r_s4_dd, r_s4_ds;
    logic signed [27:0] r_s5_ref;
    logic signed [49:0] r_s5_pd, r_s5_ps;
    logic signed [27:0] r_s6_ref;
    logic [AW-1:0]      r_s6_a00, r_s6_a10, r_s6_a01, r_s6_a11;
    logic [33:0]        r_s6_w00, r_s6_w10, r_s6_w01, r_s6_w11;
    logic signed [27:0] r_s7_ref;
    logic [33:0]        r_s7_w00, r_s7_w10, r_s7_w01, r_s7_w11;
    logic signed [19:0] r_s7_q00, r_s7_q10, r_s7_q01, r_s7_q11;
    logic signed [27:0] r_s8_ref;
    logic signed [54:0] r_s8_p00, r_s8_p10, r_s8_p01, r_s8_p11;
    logic signed [33:0] r_s9_tot;
    logic signed [19:0] r_o_fs;
    logic               r_o_ns;

    // Two copies of the table, each with two read ports.
    logic signed [19:0] mem_a [lgbfl_pkg::TABLE_DEPTH];
    logic signed [19:0] mem_b [lgbfl_pkg::TABLE_DEPTH];

    // Stage 4 combinational.
    logic signed [23:0] s4_ld, s4_lp, s4_lc, s4_lg, s4_ls;
    // Stage 6 combinational.
    lgbfl_pkg::t_gpos   s6_gd, s6_gs;
    logic [16:0]        s6_wd0, s6_ws0;
    logic [IW-1:0]      s6_d1, s6_s1;
    // Stage 9 combinational.
    logic signed [56:0] s9_sum;
    logic signed [32:0] s9_att;
    // Output combinational.
    logic signed [33:0] o_rnd;
    logic signed [25:0] o_res;
    logic signed [19:0] o_sat;
    logic               mem_we;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        go[10] = !r_o_valid || i_out_ready;
        for (int k = 9; k >= 1; k--) begin
            go[k] = !r_v[k] || go[k+1];
        end
    end

    assign o_in_ready = go[1];
    assign mem_we     = r_v[6] && (r_op[6] == lgbfl_pkg::OP_LOAD) && go[7];

    always_comb begin
        s4_ld = lgbfl_pkg::log10_round(r_s3_pd);
        s4_lp = lgbfl_pkg::log10_round(r_s3_pp);
        s4_lc = lgbfl_pkg::log10_round(r_s3_pc);
        s4_lg = (s4_ld < lgbfl_pkg::DIST_FLOOR_LOG) ? lgbfl_pkg::DIST_FLOOR_LOG : s4_ld;
        if (r_cz[3] || s4_lc < lgbfl_pkg::SIGMA_FLOOR_LOG) begin
            s4_ls = lgbfl_pkg::SIGMA_FLOOR_LOG;
        end else begin
            s4_ls = s4_lc;
        end
    end

    always_comb begin
        s6_gd  = lgbfl_pkg::grid_pos(r_s5_pd, DLAST);
        s6_gs  = lgbfl_pkg::grid_pos(r_s5_ps, SLAST);
        s6_wd0 = 17'd65536 - s6_gd.t;
        s6_ws0 = 17'd65536 - s6_gs.t;
        s6_d1  = s6_gd.idx + 1'b1;
        s6_s1  = s6_gs.idx + 1'b1;
    end

    always_comb begin
        s9_sum = 57'(r_s8_p00) + 57'(r_s8_p10) + 57'(r_s8_p01) + 57'(r_s8_p11);
        s9_att = 33'((s9_sum + 57'sd8388608) >>> 24);
        o_rnd  = r_s9_tot + 34'sd128;
        o_res  = 26'(o_rnd >>> 8);
        if (o_res > 26'(lgbfl_pkg::FS_MAX)) begin
            o_sat = lgbfl_pkg::FS_MAX;
        end else if (o_res < 26'(lgbfl_pkg::FS_MIN)) begin
            o_sat = lgbfl_pkg::FS_MIN;
        end else begin
            o_sat = 20'(o_res);
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v             <= '0;
            r_o_valid       <= 1'b0;
            r_log_dist_min  <= lgbfl_pkg::LOG_DIST_MIN_RST;
            r_dist_steps    <= lgbfl_pkg::DIST_STEPS_RST;
            r_log_sigma_min <= lgbfl_pkg::LOG_SIGMA_MIN_RST;
            r_sigma_steps   <= lgbfl_pkg::SIGMA_STEPS_RST;
        end else begin
            if (go[1]) r_v[1] <= i_in_valid;
            for (int k = 2; k <= 9; k++) begin
                if (go[k]) r_v[k] <= r_v[k-1];
            end
            if (go[10]) r_o_valid <= r_v[9] && (r_op[9] == lgbfl_pkg::OP_QUERY);
            if (i_cfg_valid) begin
                case (lgbfl_pkg::t_cfg_idx'(i_cfg_index))
                    lgbfl_pkg::CFG_LOG_DIST_MIN:  r_log_dist_min  <= i_cfg_data[18:0];
                    lgbfl_pkg::CFG_DIST_STEPS:    r_dist_steps    <= i_cfg_data;
                    lgbfl_pkg::CFG_LOG_SIGMA_MIN: r_log_sigma_min <= i_cfg_data[18:0];
                    lgbfl_pkg::CFG_SIGMA_STEPS:   r_sigma_steps   <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Payload.
    always_ff @(posedge i_clk) begin
        if (go[1]) begin
            r_op[1]  <= i_operation;
            r_ns[1]  <= (i_distance == '0) || (i_power == '0);
            r_cz[1]  <= (i_conductivity == '0);
            r_idx[1] <= i_entry_index;
            r_val[1] <= i_entry_value;
            r_s1_nd  <= lgbfl_pkg::log2_norm({8'b0, i_distance});
            r_s1_np  <= lgbfl_pkg::log2_norm(i_power);
            r_s1_nc  <= lgbfl_pkg::log2_norm({8'b0, i_conductivity});
        end
        for (int k = 2; k <= 9; k++) begin
            if (go[k]) begin
                r_op[k] <= r_op[k-1];
                r_ns[k] <= r_ns[k-1];
            end
        end
        for (int k = 2; k <= 3; k++) begin
            if (go[k]) r_cz[k] <= r_cz[k-1];
        end
        for (int k = 2; k <= 6; k++) begin
            if (go[k]) begin
                r_idx[k] <= r_idx[k-1];
                r_val[k] <= r_val[k-1];
            end
        end
        if (go[2]) begin
            r_s2_ld <= lgbfl_pkg::log2_q16(r_s1_nd, 5'd8);
            r_s2_lp <= lgbfl_pkg::log2_q16(r_s1_np, 5'd0);
            r_s2_lc <= lgbfl_pkg::log2_q16(r_s1_nc, 5'd20);
        end
        if (go[3]) begin
            r_s3_pd <= 44'(r_s2_ld) * 44'(lgbfl_pkg::LOG10_2_Q20);
            r_s3_pp <= 44'(r_s2_lp) * 44'(lgbfl_pkg::LOG10_2_Q20);
            r_s3_pc <= 44'(r_s2_lc) * 44'(lgbfl_pkg::LOG10_2_Q20);
        end
        if (go[4]) begin
            r_s4_ref <= lgbfl_pkg::REF_DB_Q16 + 28'(s4_lp) * 28'sd10 - 28'(s4_ld) * 28'sd20;
            r_s4_dd  <= 25'(s4_lg) - 25'(r_log_dist_min);
            r_s4_ds  <= 25'(s4_ls) - 25'(r_log_sigma_min);
        end
        if (go[5]) begin
            r_s5_ref <= r_s4_ref;
            r_s5_pd  <= 50'(r_s4_dd) * $signed({26'b0, r_dist_steps});
            r_s5_ps  <= 50'(r_s4_ds) * $signed({26'b0, r_sigma_steps});
        end
        if (go[6]) begin
            r_s6_ref <= r_s5_ref;
            r_s6_a00 <= AW'(32'(s6_gd.idx) * 32'(SIGMA_POINTS) + 32'(s6_gs.idx));
            r_s6_a10 <= AW'(32'(s6_d1) * 32'(SIGMA_POINTS) + 32'(s6_gs.idx));
            r_s6_a01 <= AW'(32'(s6_gd.idx) * 32'(SIGMA_POINTS) + 32'(s6_s1));
            r_s6_a11 <= AW'(32'(s6_d1) * 32'(SIGMA_POINTS) + 32'(s6_s1));
            r_s6_w00 <= 34'(s6_wd0) * 34'(s6_ws0);
            r_s6_w10 <= 34'(s6_gd.t) * 34'(s6_ws0);
            r_s6_w01 <= 34'(s6_wd0) * 34'(s6_gs.t);
            r_s6_w11 <= 34'(s6_gd.t) * 34'(s6_gs.t);
        end
        if (go[7]) begin
            r_s7_ref <= r_s6_ref;
            r_s7_w00 <= r_s6_w00;
            r_s7_w10 <= r_s6_w10;
            r_s7_w01 <= r_s6_w01;
            r_s7_w11 <= r_s6_w11;
        end
        if (go[8]) begin
            r_s8_ref <= r_s7_ref;
            r_s8_p00 <= 55'(r_s7_q00) * $signed({21'b0, r_s7_w00});
            r_s8_p10 <= 55'(r_s7_q10) * $signed({21'b0, r_s7_w10});
            r_s8_p01 <= 55'(r_s7_q01) * $signed({21'b0, r_s7_w01});
            r_s8_p11 <= 55'(r_s7_q11) * $signed({21'b0, r_s7_w11});
        end
        if (go[9]) begin
            r_s9_tot <= 34'(r_s8_ref) + 34'(s9_att);
        end
        if (go[10]) begin
            r_o_ns <= r_ns[9];
            r_o_fs <= r_ns[9] ? lgbfl_pkg::NO_SIGNAL_DB : o_sat;
        end
    end

    // Loads write as they leave stage 6, the same place queries read, so order holds.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem_a[r_idx[6]] <= r_val[6];
        end
        if (go[7]) begin
            r_s7_q00 <= mem_a[r_s6_a00];
            r_s7_q10 <= mem_a[r_s6_a10];
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem_b[r_idx[6]] <= r_val[6];
        end
        if (go[7]) begin
            r_s7_q01 <= mem_b[r_s6_a01];
            r_s7_q11 <= mem_b[r_s6_a11];
        end
    end

    assign o_out_valid      = r_o_valid;
    assign o_field_strength = r_o_fs;
    assign o_no_signal      = r_o_ns;

endmodule

@@ hw/rtl/lgbfl_chk.sv @@
`timescale 1ns / 1ps
module lgbfl_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic signed [19:0] o_field_strength,
    input logic               o_no_signal
);

    // A stalled result word holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_field_strength) && $stable(o_no_signal))
        else $error("result word changed while stalled");

    // The no-signal flag always comes with the -200 dB code.
    a_no_signal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_no_signal |-> o_field_strength == lgbfl_pkg::NO_SIGNAL_DB)
        else $error("no_signal without -200 dB");

    // Input back-pressure only ever comes from a stalled output.
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid && !i_out_ready)
        else $error("input not ready while output is free");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result word present after reset");

endmodule

bind log_grid_bilinear_field_lookup lgbfl_chk u_lgbfl_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_in_ready       (o_in_ready),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_field_strength (o_field_strength),
    .o_no_signal      (o_no_signal)
);

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
module testbench;

    localparam int ROWS       = 64;
    localparam int COLS       = 16;
    localparam int WATCHDOG   = 3000;
    localparam longint LOG10_2 = 315653;
    localparam longint REF_DB  = 3246812;
    localparam longint D_FLOOR = -65536;
    localparam longint S_FLOOR = -216335;

    typedef struct {
        logic signed [19:0] fs;
        logic               ns;
    } t_field_word;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic               i_operation;
    logic [9:0]         i_entry_index;
    logic signed [19:0] i_entry_value;
    logic [23:0]        i_distance;
    logic [23:0]        i_conductivity;
    logic [31:0]        i_power;
    logic               o_out_valid;
    logic               i_out_ready;
    logic signed [19:0] o_field_strength;
    logic               o_no_signal;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [1:0]         i_cfg_index;
    logic [23:0]        i_cfg_data;

    log_grid_bilinear_field_lookup uut (.*);

    // Local copy of the grid origin, step registers and attenuation table.
    longint             m_dist_min;
    longint             m_dist_steps;
    longint             m_sigma_min;
    longint             m_sigma_steps;
    logic signed [19:0] m_atten [1024];
    longint             seg_tab [17] = '{0, 5732, 11136, 16248, 21098, 25711, 30109,
                                         34312, 38336, 42196, 45904, 49472, 52911,
                                         56229, 59434, 62534, 65536};

    t_field_word expected_fields[$];
    int          mismatches;
    int          idle_cycles;
    bit          idle_on;
    bit          rx_hold;
    int          rx_left;
    bit          rx_state;

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    function automatic longint rnd_shift(longint v, int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint log2_fix(logic [31:0] x);
        int          e;
        logic [31:0] n;
        int          k;
        longint      r;
        e = 0;
        for (int b = 0; b < 32; b++) begin
            if (x[b]) e = b;
        end
        n = x << (31 - e);
        k = int'(n[30:27]);
        r = longint'({37'b0, n[26:0]});
        return longint'(e) * 65536 + seg_tab[k] + (((seg_tab[k + 1] - seg_tab[k]) * r) >>> 27);
    endfunction

    function automatic longint log10_fix(logic [31:0] x, int frac_bits);
        return rnd_shift((log2_fix(x) - longint'(frac_bits) * 65536) * LOG10_2, 20);
    endfunction

    task automatic grid_locate(input longint logv, input longint lmin, input longint steps,
                               input int points, output int i0, output longint t);
        longint pos;
        longint top;
        longint i;
        pos = (logv - lmin) * steps;
        top = longint'(points - 1) <<< 32;
        if (pos < 0) pos = 0;
        if (pos > top) pos = top;
        i = pos >>> 32;
        if (i > points - 2) i = points - 2;
        i0 = int'(i);
        t  = (pos - (i <<< 32)) >>> 16;
    endtask

    function automatic longint atten_at(int row, int col);
        return longint'(m_atten[(row * COLS + col) & 1023]);
    endfunction

    task automatic predict_field(input logic [23:0] path_len, input logic [23:0] cond,
                                 input logic [31:0] pwr, output t_field_word w);
        longint ld, lg, ls, ref_db, td, ts, wd0, ws0, acc, res;
        int     di, si;
        if (path_len == 0 || pwr == 0) begin
            w.fs = -20'sd51200;
            w.ns = 1'b1;
            return;
        end
        ld     = log10_fix({8'b0, path_len}, 8);
        ref_db = REF_DB + 10 * log10_fix(pwr, 0) - 20 * ld;
        lg     = (ld < D_FLOOR) ? D_FLOOR : ld;
        ls     = (cond == 0) ? S_FLOOR : log10_fix({8'b0, cond}, 20);
        if (ls < S_FLOOR) ls = S_FLOOR;
        grid_locate(lg, m_dist_min, m_dist_steps, ROWS, di, td);
        grid_locate(ls, m_sigma_min, m_sigma_steps, COLS, si, ts);
        wd0 = 65536 - td;
        ws0 = 65536 - ts;
        acc = atten_at(di, si) * (wd0 * ws0) + atten_at(di + 1, si) * (td * ws0)
            + atten_at(di, si + 1) * (wd0 * ts) + atten_at(di + 1, si + 1) * (td * ts);
        res = rnd_shift(ref_db + rnd_shift(acc, 24), 8);
        if (res > 524287) res = 524287;
        if (res < -524288) res = -524288;
        w.fs = 20'(res);
        w.ns = 1'b0;
    endtask

    // Sends one word; called at a rising edge and returns at the edge that accepts it.
    task automatic send_word(input lgbfl_pkg::t_op op, input logic [9:0] idx,
                             input logic [19:0] val, input logic [23:0] path_len,
                             input logic [23:0] cond, input logic [31:0] pwr);
        t_field_word w;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_operation    <= op;
        i_entry_index  <= idx;
        i_entry_value  <= val;
        i_distance     <= path_len;
        i_conductivity <= cond;
        i_power        <= pwr;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        if (op == lgbfl_pkg::OP_LOAD) begin
            m_atten[idx] = val;
        end else begin
            predict_field(path_len, cond, pwr, w);
            expected_fields.push_back(w);
        end
    endtask

    task automatic send_load(input logic [9:0] idx, input logic [19:0] val);
        send_word(lgbfl_pkg::OP_LOAD, idx, val, 24'($urandom), 24'($urandom), $urandom);
    endtask

    task automatic send_query(input logic [23:0] path_len, input logic [23:0] cond,
                              input logic [31:0] pwr);
        send_word(lgbfl_pkg::OP_QUERY, 10'($urandom), 20'($urandom), path_len, cond, pwr);
    endtask

    // Values spread over many decades so every grid region is reached.
    function automatic logic [31:0] log_spread(int bits);
        logic [31:0] v;
        v = $urandom;
        if ($urandom_range(0, 15) == 0) return '0;
        return 32'(v & ((64'd1 << $urandom_range(1, bits)) - 1));
    endfunction

    function automatic logic [19:0] random_atten();
        if ($urandom_range(0, 9) == 0) return 20'($urandom);
        return 20'($signed($urandom_range(0, 51200)) - 25600);
    endfunction

    task automatic random_query();
        send_query(24'(log_spread(24)), 24'(log_spread(24)), log_spread(32));
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (expected_fields.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic write_reg(input lgbfl_pkg::t_cfg_idx idx, input logic [23:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            lgbfl_pkg::CFG_LOG_DIST_MIN:  m_dist_min    = longint'($signed(data[18:0]));
            lgbfl_pkg::CFG_DIST_STEPS:    m_dist_steps  = longint'({40'b0, data});
            lgbfl_pkg::CFG_LOG_SIGMA_MIN: m_sigma_min   = longint'($signed(data[18:0]));
            lgbfl_pkg::CFG_SIGMA_STEPS:   m_sigma_steps = longint'({40'b0, data});
            default: ;
        endcase
    endtask

    task automatic set_grid(input int dmin, input int dsteps, input int smin, input int ssteps);
        write_reg(lgbfl_pkg::CFG_LOG_DIST_MIN, 24'(dmin));
        write_reg(lgbfl_pkg::CFG_DIST_STEPS, 24'(dsteps));
        write_reg(lgbfl_pkg::CFG_LOG_SIGMA_MIN, 24'(smin));
        write_reg(lgbfl_pkg::CFG_SIGMA_STEPS, 24'(ssteps));
    endtask

    task automatic test_fill_table();
        for (int a = 0; a < 1024; a++) send_load(10'(a), random_atten());
    endtask

    task automatic test_directed();
        send_load(10'd0, 20'sd524287);
        send_load(10'd1023, -20'sd524288);
        send_query(24'd0, 24'd1048576, 32'd1000);
        send_query(24'd25600, 24'd1048576, 32'd0);
        send_query(24'd0, 24'd0, 32'd0);
        send_query(24'd1, 24'd0, 32'hFFFF_FFFF);
        send_query(24'hFF_FFFF, 24'hFF_FFFF, 32'd1);
        send_query(24'd25, 24'd524, 32'd1_000_000);
        send_query(24'd25600, 24'd1048576, 32'd1_000_000);
        send_query(24'd256, 24'd1, 32'd1);
        send_query(24'd26, 24'd525, 32'h8000_0000);
        send_load(10'd0, random_atten());
        send_load(10'd1023, random_atten());
        send_query(24'd1, 24'd0, 32'hFFFF_FFFF);
        send_query(24'hFF_FFFF, 24'hFF_FFFF, 32'd1);
        drain();
    endtask

    task automatic test_grid_settings();
        set_grid(-262144, 1, -262144, 1);
        repeat (30) random_query();
        drain();
        set_grid(262143, 16777215, 262143, 16777215);
        repeat (30) random_query();
        drain();
        set_grid(-262144, 16777215, 0, 0);
        repeat (30) random_query();
        drain();
        set_grid(0, 0, -216335, 983040);
        repeat (30) random_query();
        drain();
        set_grid(-65536, 655360, -216335, 262144);
    endtask

    task automatic test_backpressure();
        rx_hold = 1'b1;
        fork
            begin
                repeat (200) @(posedge i_clk);
                rx_hold = 1'b0;
            end
        join_none
        repeat (40) random_query();
        drain();
    endtask

    task automatic test_random_mix(input int n);
        for (int j = 0; j < n; j++) begin
            if (j == n - 40) idle_on = 1'b0;
            if ($urandom_range(0, 9) < 3) send_load(10'($urandom), random_atten());
            else random_query();
        end
        drain();
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_operation    = lgbfl_pkg::OP_LOAD;
        i_entry_index  = '0;
        i_entry_value  = '0;
        i_distance     = '0;
        i_conductivity = '0;
        i_power        = '0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = lgbfl_pkg::CFG_LOG_DIST_MIN;
        i_cfg_data     = '0;
        mismatches     = 0;
        idle_on        = 1'b1;
        rx_hold        = 1'b0;
        m_dist_min     = -65536;
        m_dist_steps   = 655360;
        m_sigma_min    = -216335;
        m_sigma_steps  = 262144;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_fill_table();
        test_directed();
        test_grid_settings();
        test_backpressure();
        test_random_mix(110);
        if (mismatches == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

    // Receiver readiness: random bursts, or a held-off stretch when asked.
    initial begin
        i_out_ready = 1'b0;
        rx_left     = 0;
        rx_state    = 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold) begin
                i_out_ready <= 1'b0;
            end else begin
                if (rx_left == 0) begin
                    if (rx_state && idle_on) begin
                        rx_state = 1'b0;
                        rx_left  = $urandom_range(1, 8);
                    end else begin
                        rx_state = 1'b1;
                        rx_left  = $urandom_range(1, 30);
                    end
                end
                rx_left--;
                i_out_ready <= rx_state;
            end
        end
    end

    always @(posedge i_clk) begin
        t_field_word w;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_fields.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word fs=%0d ns=%0b", o_field_strength,
                             o_no_signal);
            end else begin
                w = expected_fields.pop_front();
                if (o_field_strength !== w.fs || o_no_signal !== w.ns) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected fs=%0d ns=%0b, got fs=%0d ns=%0b",
                                 w.fs, w.ns, o_field_strength, o_no_signal);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG) begin
            $display("testbench failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
